/* hw/rtl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

    localparam int DEPTH_DEFAULT       = 256;
    localparam int MAX_PATTERN_DEFAULT = 8;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int PAT_W   = 64;
    localparam int PLEN_W  = 4;
    localparam int PAT_BYTES = PAT_W / BYTE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_LOOK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_LOOK,
        ST_HOLD
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/byte_ring_buffer_with_pattern_search.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_pattern_search
// Byte ring store with separate write and read positions and a pattern
// look-for that scans the raw store from index 0 as a zero-terminated string.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  (i_in_valid / o_in_ready): one op per transaction, with
//     push byte, pattern bytes and pattern length
//   output channel (o_out_valid / i_out_ready): exactly one result per op
//   config channel (i_cfg_valid / o_cfg_ready): size in use; a write also
//     clears the store, takes effect only while the block is idle
// Op behaviour:
//   push  byte written to the store, result registered as the op is taken
//   pop   bounded by the registered read port of the store RAM
//   look  one store byte per cycle through the read port, stops early at a
//     zero byte or on a match
//   flush one store entry cleared per cycle
// Reset: a clearing pass over min(256, DEPTH) entries zeroes the store; no op is
//   taken until it ends (config writes after it). A size write starts the
//   same pass over the new size.
// Stall: an op is taken while an earlier result waits in the output register;
//   its own result then waits in a holding register until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_pattern_search #(
    parameter int DEPTH       = brb_pkg::DEPTH_DEFAULT,
    parameter int MAX_PATTERN = brb_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [brb_pkg::SIZE_W-1:0] i_cfg_size_in_use,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_op,
    input  wire logic [brb_pkg::BYTE_W-1:0] i_push_byte,
    input  wire logic [brb_pkg::PAT_W-1:0]  i_pattern_bytes,
    input  wire logic [brb_pkg::PLEN_W-1:0] i_pattern_length,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [brb_pkg::BYTE_W-1:0] o_pop_byte,
    output logic                            o_found
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = AW + 1;
    localparam int BW     = brb_pkg::BYTE_W;
    localparam int PLW    = brb_pkg::PLEN_W;

    brb_pkg::t_state r_state, n_state;

    logic [brb_pkg::SIZE_W-1:0] r_size, n_size;
    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [AW-1:0] r_rd_pos, n_rd_pos;
    logic [CW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_res, n_clr_res;
    logic [CW-1:0] r_scan_addr, n_scan_addr;
    logic          r_rd_vld, n_rd_vld;
    logic [PLW-1:0] r_plen, n_plen;
    logic [BW-1:0] r_rpat [MAX_PATTERN];
    logic [BW-1:0] n_rpat [MAX_PATTERN];
    logic [BW-1:0] r_win [MAX_PATTERN];
    logic [BW-1:0] n_win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_wvld, n_wvld;
    logic          r_out_vld, n_out_vld;
    logic [BW-1:0] r_out_pop, n_out_pop;
    logic          r_out_found, n_out_found;
    logic [BW-1:0] r_res_pop, n_res_pop;
    logic          r_res_found, n_res_found;

    logic [CW-1:0] eff_size;
    logic          cfg_acc;
    logic          in_acc;
    brb_pkg::t_op  op;
    logic          out_free;
    logic          clr_last;
    logic          look_done;
    logic          look_found;
    logic          res_done;
    logic [BW-1:0] res_pop;
    logic          res_found;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [BW-1:0] mem_q;

    logic [BW-1:0] pb [brb_pkg::PAT_BYTES];
    logic [PLW-1:0] pat_lim;
    logic [PLW-1:0] pat_len;
    logic [BW-1:0] pat_rev [MAX_PATTERN];
    logic [BW-1:0] nw [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] nv;
    logic          win_match;

    brb_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    assign eff_size = (r_size == '0) ? CW'(1) :
                      ((int'(r_size) > DEPTH) ? CW'(DEPTH) : CW'(r_size));

    assign o_cfg_ready = (r_state == brb_pkg::ST_IDLE);
    assign o_in_ready  = (r_state == brb_pkg::ST_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign op          = brb_pkg::t_op'(i_op);
    assign out_free    = !r_out_vld || i_out_ready;
    assign clr_last    = (r_clr_addr == eff_size - CW'(1));

    assign wr_next = ({1'b0, r_wr_pos} + CW'(1) >= eff_size) ? '0 : r_wr_pos + AW'(1);
    assign rd_next = ({1'b0, r_rd_pos} + CW'(1) >= eff_size) ? '0 : r_rd_pos + AW'(1);

    // pattern set-up: effective length and reversed byte order
    always_comb begin
        logic go;
        logic [PLW-1:0] ridx;
        go = 1'b1;
        ridx = '0;
        for (int m = 0; m < brb_pkg::PAT_BYTES; m++) begin
            pb[m] = i_pattern_bytes[m*BW +: BW];
        end
        pat_lim = (i_pattern_length > PLW'(MAX_PATTERN)) ? PLW'(MAX_PATTERN)
                                                          : i_pattern_length;
        pat_len = '0;
        for (int m = 0; m < MAX_PATTERN; m++) begin
            if (go && (PLW'(m) < pat_lim) && (pb[m] != 8'h00)) begin
                pat_len = PLW'(m + 1);
            end else begin
                go = 1'b0;
            end
        end
        for (int m = 0; m < MAX_PATTERN; m++) begin
            ridx = pat_len - PLW'(m) - PLW'(1);
            pat_rev[m] = pb[ridx[2:0]];
        end
    end

    // window of the most recent scanned bytes, newest first
    always_comb begin
        nw[0] = mem_q;
        nv[0] = 1'b1;
        for (int m = 1; m < MAX_PATTERN; m++) begin
            nw[m] = r_win[m-1];
            nv[m] = r_wvld[m-1];
        end
        win_match = 1'b1;
        for (int m = 0; m < MAX_PATTERN; m++) begin
            if ((PLW'(m) < r_plen) && !(nv[m] && (nw[m] == r_rpat[m]))) begin
                win_match = 1'b0;
            end
        end
    end

    always_comb begin
        look_done  = 1'b0;
        look_found = 1'b0;
        if (r_rd_vld) begin
            if (mem_q == 8'h00) begin
                look_done = 1'b1;
            end else if (win_match) begin
                look_done  = 1'b1;
                look_found = 1'b1;
            end
        end else if (r_scan_addr >= eff_size) begin
            look_done = 1'b1;
        end
    end

    always_comb begin
        res_done  = 1'b0;
        res_pop   = '0;
        res_found = 1'b0;
        unique case (r_state)
            brb_pkg::ST_CLEAR: res_done = clr_last && r_clr_res;
            brb_pkg::ST_IDLE:  res_done = in_acc && (op == brb_pkg::OP_PUSH);
            brb_pkg::ST_POP: begin
                res_done = 1'b1;
                res_pop  = mem_q;
            end
            brb_pkg::ST_LOOK: begin
                res_done  = look_done;
                res_found = look_found;
            end
            brb_pkg::ST_HOLD:  res_done = 1'b0;
            default:           res_done = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (res_done) begin
            n_state = out_free ? brb_pkg::ST_IDLE : brb_pkg::ST_HOLD;
        end else begin
            unique case (r_state)
                brb_pkg::ST_CLEAR: begin
                    if (clr_last) begin
                        n_state = brb_pkg::ST_IDLE;
                    end
                end
                brb_pkg::ST_IDLE: begin
                    if (cfg_acc) begin
                        n_state = brb_pkg::ST_CLEAR;
                    end else if (in_acc) begin
                        unique case (op)
                            brb_pkg::OP_POP:   n_state = brb_pkg::ST_POP;
                            brb_pkg::OP_FLUSH: n_state = brb_pkg::ST_CLEAR;
                            brb_pkg::OP_LOOK:  n_state = brb_pkg::ST_LOOK;
                            default:           n_state = brb_pkg::ST_IDLE;
                        endcase
                    end
                end
                brb_pkg::ST_POP:  n_state = brb_pkg::ST_POP;
                brb_pkg::ST_LOOK: n_state = brb_pkg::ST_LOOK;
                brb_pkg::ST_HOLD: begin
                    if (out_free) begin
                        n_state = brb_pkg::ST_IDLE;
                    end
                end
                default: n_state = brb_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_size      = r_size;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_clr_addr  = r_clr_addr;
        n_clr_res   = r_clr_res;
        n_scan_addr = r_scan_addr;
        n_rd_vld    = 1'b0;
        n_plen      = r_plen;
        n_rpat      = r_rpat;
        n_win       = r_win;
        n_wvld      = r_wvld;
        n_res_pop   = r_res_pop;
        n_res_found = r_res_found;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_pop   = r_out_pop;
        n_out_found = r_out_found;

        mem_we    = 1'b0;
        mem_waddr = r_wr_pos;
        mem_wdata = i_push_byte;
        mem_raddr = r_rd_pos;

        unique case (r_state)
            brb_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr[AW-1:0];
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + CW'(1);
            end
            brb_pkg::ST_IDLE: begin
                if (cfg_acc) begin
                    n_size     = i_cfg_size_in_use;
                    n_clr_addr = '0;
                    n_clr_res  = 1'b0;
                    n_wr_pos   = '0;
                    n_rd_pos   = '0;
                end else if (in_acc) begin
                    unique case (op)
                        brb_pkg::OP_PUSH: begin
                            mem_we   = 1'b1;
                            n_wr_pos = wr_next;
                        end
                        brb_pkg::OP_POP: begin
                            n_rd_pos = rd_next;
                        end
                        brb_pkg::OP_FLUSH: begin
                            n_clr_addr = '0;
                            n_clr_res  = 1'b1;
                            n_wr_pos   = '0;
                            n_rd_pos   = '0;
                        end
                        default: begin
                            n_plen      = pat_len;
                            n_rpat      = pat_rev;
                            n_scan_addr = '0;
                            n_wvld      = '0;
                        end
                    endcase
                end
            end
            brb_pkg::ST_LOOK: begin
                mem_raddr   = r_scan_addr[AW-1:0];
                n_scan_addr = r_scan_addr + CW'(1);
                n_rd_vld    = (r_scan_addr < eff_size);
                if (r_rd_vld) begin
                    n_win  = nw;
                    n_wvld = nv;
                end
            end
            brb_pkg::ST_POP: begin
                mem_raddr = r_rd_pos;
            end
            brb_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_pop   = r_res_pop;
                    n_out_found = r_res_found;
                end
            end
            default: begin
                mem_raddr = r_rd_pos;
            end
        endcase

        if (res_done) begin
            if (out_free) begin
                n_out_vld   = 1'b1;
                n_out_pop   = res_pop;
                n_out_found = res_found;
            end else begin
                n_res_pop   = res_pop;
                n_res_found = res_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brb_pkg::ST_CLEAR;
            r_size      <= brb_pkg::SIZE_RESET;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_clr_addr  <= '0;
            r_clr_res   <= 1'b0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_wvld      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_clr_addr  <= n_clr_addr;
            r_clr_res   <= n_clr_res;
            r_scan_addr <= n_scan_addr;
            r_rd_vld    <= n_rd_vld;
            r_wvld      <= n_wvld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen      <= n_plen;
        r_rpat      <= n_rpat;
        r_win       <= n_win;
        r_out_pop   <= n_out_pop;
        r_out_found <= n_out_found;
        r_res_pop   <= n_res_pop;
        r_res_found <= n_res_found;
    end

    assign o_out_valid = r_out_vld;
    assign o_pop_byte  = r_out_pop;
    assign o_found     = r_out_found;

    // checks
    a_hold_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brb_pkg::ST_HOLD) |-> r_out_vld)
        else $error("holding a result while the output register is empty");

    a_clear_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brb_pkg::ST_CLEAR) |-> (r_clr_addr < eff_size))
        else $error("clearing pass beyond the size in use");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wr_pos} < eff_size) && ({1'b0, r_rd_pos} < eff_size))
        else $error("ring position beyond the size in use");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (op == brb_pkg::OP_PUSH) && out_free)
        |=> (o_out_valid && (o_pop_byte == '0) && !o_found))
        else $error("push transaction without a cleared result");

endmodule

`default_nettype wire

/* hw/rtl/brb_ram.sv */
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
